/* sv/sorted_score_rank_table_macros.svh */
// Assertion macros used by the RTL of sorted_score_rank_table.
// The clock is clk and the reset is rst in every module that uses them.
`ifndef SORTED_SCORE_RANK_TABLE_MACROS_SVH
`define SORTED_SCORE_RANK_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond holds at every clock edge outside reset
`define SSRT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// ante at an edge implies cons at the same edge
`define SSRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define SSRT_ASSERT_ALWAYS(lbl, cond)
`define SSRT_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

/* sv/ssrt_pkg.sv */
`timescale 1ns / 1ps

package ssrt_pkg;

  localparam int MarkW  = 7;
  localparam int ScoreW = 11;
  localparam int RankW  = 7;
  localparam int CountW = 7;

  localparam logic [MarkW-1:0] MarkMax = 7'd100;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  typedef logic [MarkW-1:0]  mark_t;
  typedef logic [ScoreW-1:0] score_t;

  // Input word: tdata holds mark_one then mark_two, tuser holds req_type
  localparam int InDataW  = 16;
  // Output word: rank, top_score, entry_count, table_full, zero fill
  localparam int OutDataW = 32;

endpackage

/* sv/ssrt_score.sv */
`timescale 1ns / 1ps

module ssrt_score (
  input  ssrt_pkg::mark_t  mark_one,
  input  ssrt_pkg::mark_t  mark_two,
  output ssrt_pkg::score_t score
);
  import ssrt_pkg::*;

  mark_t        m1;
  mark_t        m2;
  logic [7:0]   msum;

  // clamp each mark to the top of its range
  assign m1   = (mark_one > MarkMax) ? MarkMax : mark_one;
  assign m2   = (mark_two > MarkMax) ? MarkMax : mark_two;
  assign msum = {1'b0, m1} + {1'b0, m2};

  // times ten as eight plus two
  assign score = {msum, 3'b000} + {2'b00, msum, 1'b0};

endmodule

/* sv/sorted_score_rank_table.sv */
`timescale 1ns / 1ps
// Channel  Dir  tdata                                   tuser
// s_*      in   [6:0] mark_one, [13:7] mark_two         [0] req_type
// m_*      out  [6:0] rank, [17:7] top_score,           none
//               [24:18] entry_count, [25] table_full
//
// One word in, one word out; a new word is taken only while idle. A query compares
// entries in order up to a match, a smaller entry or the last entry (at most TABLE_DEPTH);
// an insert shifts the smaller entries down, and an insert into a full table is refused.
// One memory read port, one entry a cycle, sets the walk; rst is synchronous and
// the table needs no clearing, only the first entry_count entries are ever compared.
// A waiting result holds the sequencer only once the next result is ready.

module sorted_score_rank_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ssrt_pkg::InDataW-1:0]  s_tdata,   // mark_one, mark_two
  input  logic                          s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ssrt_pkg::OutDataW-1:0] m_tdata    // rank, top_score, entry_count, table_full
);
  import ssrt_pkg::*;

  `include "sorted_score_rank_table_macros.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CMP = 3'd1;
  localparam logic [2:0] ST_INS_PUT = 3'd2;
  localparam logic [2:0] ST_QRY_CMP = 3'd3;
  localparam logic [2:0] ST_OUT     = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] stored_count;
  score_t        top_score;
  score_t        score_reg;
  logic [CW-1:0] pos;
  logic [CW-1:0] res_rank;
  logic          res_full;

  score_t        score_in;
  logic          s_fire;

  score_t        mem [TABLE_DEPTH];
  score_t        rdata;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  score_t        wr_data;

  logic          lt;
  logic          eq;

  ssrt_score u_score (
    .mark_one (s_tdata[MarkW-1:0]),
    .mark_two (s_tdata[2*MarkW-1:MarkW]),
    .score    (score_in)
  );

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // shared compare of the entry just read against the held score
  assign lt = (rdata < score_reg);
  assign eq = (rdata == score_reg);

  always_comb begin
    unique case (state)
      ST_IDLE:    rd_addr = (s_tuser == ReqInsert) ? AW'(stored_count - CW'(1)) : '0;
      ST_INS_CMP: rd_addr = AW'(pos - CW'(2));
      ST_QRY_CMP: rd_addr = AW'(pos + CW'(1));
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_addr = AW'(pos);
    unique case (state)
      ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_data = lt ? rdata : score_reg;
      end
      ST_INS_PUT: begin
        wr_en   = 1'b1;
        wr_data = score_reg;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = score_reg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_count <= '0;
      top_score    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // drop the sent word unless a new one goes out this cycle
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            score_reg <= score_in;
            res_rank  <= '0;
            res_full  <= 1'b0;
            if (s_tuser == ReqInsert) begin
              pos <= stored_count;
              if (stored_count >= Depth) begin
                res_full <= 1'b1;
                state    <= ST_OUT;
              end else if (stored_count == '0) begin
                state <= ST_INS_PUT;
              end else begin
                state <= ST_INS_CMP;
              end
            end else begin
              pos <= '0;
              if (stored_count == '0) begin
                state <= ST_OUT;
              end else begin
                state <= ST_QRY_CMP;
              end
            end
          end
        end
        ST_INS_CMP: begin
          // shift the smaller entry down, or drop the score in behind it
          if (lt) begin
            pos <= pos - CW'(1);
            if (pos == CW'(1)) begin
              state <= ST_INS_PUT;
            end
          end else begin
            stored_count <= stored_count + CW'(1);
            state        <= ST_OUT;
          end
        end
        ST_INS_PUT: begin
          if (pos == '0) begin
            top_score <= score_reg;
          end
          stored_count <= stored_count + CW'(1);
          state        <= ST_OUT;
        end
        ST_QRY_CMP: begin
          // descending order: a smaller entry ends the search
          if (eq) begin
            res_rank <= pos + CW'(1);
            state    <= ST_OUT;
          end else if (lt || (pos + CW'(1) == stored_count)) begin
            state <= ST_OUT;
          end else begin
            pos <= pos + CW'(1);
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, res_full, CountW'(stored_count), top_score,
                         RankW'(res_rank)};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SSRT_ASSERT_ALWAYS(a_count_bound, stored_count <= Depth)
  `SSRT_ASSERT_IMPL(a_full_no_rank, state == ST_OUT && res_full, res_rank == '0)
  `SSRT_ASSERT_IMPL(a_count_step, !$past(rst),
    stored_count == $past(stored_count) || stored_count == $past(stored_count) + CW'(1))
  `SSRT_ASSERT_IMPL(a_top_mono, !$past(rst), top_score >= $past(top_score))
  `SSRT_ASSERT_IMPL(a_busy_count, state == ST_INS_CMP || state == ST_INS_PUT,
    stored_count < Depth)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ssrt_pkg::*;

  localparam int TableDepth = 64;
  localparam int RandomItems = 1630;
  localparam int IdleLimit = 3000;   // cycles without any handshake
  localparam int HoldCycles = 300;   // long receiver hold-off
  localparam int TailCycles = 80;    // longest walk plus margin
  localparam int MaxPrinted = 100;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    score_t            top_score;
    logic [CountW-1:0] entry_count;
    logic              table_full;
  } outcome_t;

  class rank_scoreboard;
    score_t   ranked[TableDepth];
    int       held;
    outcome_t pending_q[$];
    int       errors;

    function new();
      held = 0;
      errors = 0;
      foreach (ranked[i]) ranked[i] = '0;
    endfunction

    function score_t score_of(mark_t a, mark_t b);
      mark_t ca;
      mark_t cb;
      ca = (a > MarkMax) ? MarkMax : a;
      cb = (b > MarkMax) ? MarkMax : b;
      return score_t'(10 * (int'(ca) + int'(cb)));
    endfunction

    // Update the table copy and queue the result this word must produce
    function void note_word(logic req, mark_t m1, mark_t m2);
      outcome_t o;
      score_t   s;
      int       pos;
      int       i;
      o = '0;
      s = score_of(m1, m2);
      if (req == ReqInsert) begin
        if (held >= TableDepth) begin
          o.table_full = 1'b1;
        end else begin
          // land just after any equal entries
          pos = held;
          while (pos > 0 && ranked[pos-1] < s) begin
            ranked[pos] = ranked[pos-1];
            pos--;
          end
          ranked[pos] = s;
          held++;
        end
      end else begin
        i = 0;
        while (i < held && o.rank == 0) begin
          if (ranked[i] == s) o.rank = RankW'(i + 1);
          i++;
        end
      end
      o.top_score = (held > 0) ? ranked[0] : '0;
      o.entry_count = CountW'(held);
      pending_q.push_back(o);
    endfunction

    task report(string what);
      errors++;
      // keep the log readable when something breaks badly
      if (errors <= MaxPrinted) $display("mismatch: %s", what);
    endtask

    task check_word(logic [OutDataW-1:0] d);
      outcome_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("result word %h with nothing outstanding", d));
      end else begin
        e = pending_q.pop_front();
        if (d[6:0] !== e.rank)
          report($sformatf("rank %0d, want %0d", d[6:0], e.rank));
        if (d[17:7] !== e.top_score)
          report($sformatf("top_score %0d, want %0d", d[17:7], e.top_score));
        if (d[24:18] !== e.entry_count)
          report($sformatf("entry_count %0d, want %0d", d[24:18], e.entry_count));
        if (d[25] !== e.table_full)
          report($sformatf("table_full %b, want %b", d[25], e.table_full));
        if (d[31:26] !== 6'd0)
          report($sformatf("fill bits %b not zero", d[31:26]));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  rank_scoreboard sb;
  bit src_burst = 1'b0;
  bit snk_burst = 1'b0;
  int idle_run = 0;

  sorted_score_rank_table #(
    .TABLE_DEPTH(TableDepth)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // Split a mark total into two marks, sometimes above range where 100 is hit
  task automatic marks_for(input int total, output mark_t a, output mark_t b);
    int lo;
    int hi;
    lo = (total > 100) ? total - 100 : 0;
    hi = (total < 100) ? total : 100;
    a = mark_t'($urandom_range(lo, hi));
    b = mark_t'(total - int'(a));
    if (a == MarkMax && $urandom_range(0, 1)) a = mark_t'($urandom_range(100, 127));
    if (b == MarkMax && $urandom_range(0, 1)) b = mark_t'($urandom_range(100, 127));
  endtask

  task automatic send_word(input logic req, input mark_t m1, input mark_t m2);
    int gap;
    gap = pick_gap(src_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, m2, m1};
    s_tuser <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(req, m1, m2);
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run + 1 >= IdleLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) snk_burst = ($urandom_range(0, 3) == 0);
      gap = pick_gap(snk_burst);
      // long hold-offs let the block back up and stall its input
      if (taken == 400 || taken == 1100) gap = HoldCycles;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_word(m_tdata);
      taken++;
    end
  end

  initial begin : stimulus
    int    n;
    int    t;
    int    pick;
    int    ins_pct;
    logic  req;
    mark_t m1;
    mark_t m2;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, extremes, clamping, duplicates, misses
    send_word(ReqQuery, 7'd0, 7'd0);
    send_word(ReqQuery, 7'd127, 7'd127);
    send_word(ReqInsert, 7'd0, 7'd0);
    send_word(ReqQuery, 7'd0, 7'd0);
    send_word(ReqInsert, 7'd100, 7'd100);
    send_word(ReqInsert, 7'd127, 7'd127);
    send_word(ReqInsert, 7'd101, 7'd0);
    send_word(ReqInsert, 7'd50, 7'd50);
    send_word(ReqQuery, 7'd100, 7'd0);
    send_word(ReqQuery, 7'd127, 7'd127);
    send_word(ReqQuery, 7'd0, 7'd0);
    send_word(ReqQuery, 7'd1, 7'd0);
    send_word(ReqInsert, 7'd0, 7'd1);
    send_word(ReqInsert, 7'd64, 7'd63);
    send_word(ReqInsert, 7'd0, 7'd127);
    send_word(ReqInsert, 7'd127, 7'd0);
    send_word(ReqInsert, 7'd99, 7'd1);
    send_word(ReqQuery, 7'd64, 7'd63);
    send_word(ReqQuery, 7'd0, 7'd1);
    send_word(ReqQuery, 7'd85, 7'd42);
    wait_drain();

    for (n = 0; n < RandomItems; n++) begin
      if (n == 800) wait_drain();
      if (n % 64 == 0) src_burst = ($urandom_range(0, 3) == 0);
      // sparse inserts first, then denser inserts to fill the table, then mostly queries
      ins_pct = (n < 900) ? 5 : ((n < 1100) ? 30 : 8);
      req = ($urandom_range(0, 99) < ins_pct) ? ReqInsert : ReqQuery;
      pick = $urandom_range(0, 9);
      if (sb.held > 0 && pick < 7) begin
        t = int'(sb.ranked[$urandom_range(0, sb.held - 1)]) / 10;
        // near miss next to a stored score
        if (pick == 6) t = $urandom_range(0, 1) ? t + 1 : t - 1;
        if (t < 0) t = 1;
        if (t > 200) t = 199;
        marks_for(t, m1, m2);
      end else begin
        m1 = mark_t'($urandom_range(0, 127));
        m2 = mark_t'($urandom_range(0, 127));
      end
      send_word(req, m1, m2);
    end

    wait_drain();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
